>>> rtl/dlxy_pkg.sv
package dlxy_pkg;

  localparam int WORK_BITS = 30;
  localparam int U_WIDTH   = 29;
  localparam int Q_WIDTH   = 34;

  localparam logic [15:0] TEMP_LOW   = 16'd4000;
  localparam logic [15:0] TEMP_SPLIT = 16'd7000;
  localparam logic [15:0] TEMP_HIGH  = 16'd25000;
  localparam int          RECIP_NUM  = 1000;

  typedef logic signed [Q_WIDTH-1:0] dlxy_q30_t;

  typedef struct packed {
    logic rng;
    logic sel;
  } dlxy_tag_t;

  typedef struct packed {
    logic        rng;
    logic [15:0] cy;
    logic [15:0] cx;
  } dlxy_res_t;

  localparam dlxy_q30_t COEF_A1 = 34'sd4946728583;
  localparam dlxy_q30_t COEF_B1 = 34'sd3186650985;
  localparam dlxy_q30_t COEF_C1 = 34'sd106418552;
  localparam dlxy_q30_t COEF_D1 = 34'sd262060651;
  localparam dlxy_q30_t COEF_A2 = 34'sd2154355596;
  localparam dlxy_q30_t COEF_B2 = 34'sd2042042201;
  localparam dlxy_q30_t COEF_C2 = 34'sd265729627;
  localparam dlxy_q30_t COEF_D2 = 34'sd254519762;
  localparam dlxy_q30_t COEF_YA = 34'sd3221225472;
  localparam dlxy_q30_t COEF_YB = 34'sd3081639035;
  localparam dlxy_q30_t COEF_YC = 34'sd295279002;

  localparam logic signed [67:0] Q30_HALF = 68'sd1 <<< (WORK_BITS - 1);

  // drop the Q.30 fraction of a product, half away from zero
  function automatic logic signed [67-WORK_BITS:0] qround(input logic signed [67:0] p);
    logic signed [67:0] s;
    s = p + (p[67] ? (Q30_HALF - 68'sd1) : Q30_HALF);
    return s[67:WORK_BITS];
  endfunction

endpackage

>>> rtl/dlxy_recip.sv
module dlxy_recip #(
  parameter int RECIP_FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [15:0]           temp,
  output logic                  out_valid,
  output logic [28:0]           u,
  output dlxy_pkg::dlxy_tag_t   tag
);

  localparam int QW = RECIP_FRAC_BITS - 1;
  localparam int UW = dlxy_pkg::U_WIDTH;

  typedef struct packed {
    logic [14:0]         den;
    logic [14:0]         rem;
    logic [QW-1:0]       dvd;
    logic [QW-1:0]       quo;
    dlxy_pkg::dlxy_tag_t tag;
  } div_t;

  function automatic div_t div_step(input div_t s);
    logic [15:0] sh;
    logic        ge;
    div_t        r;
    sh = {s.rem, s.dvd[QW-1]};
    ge = sh >= {1'b0, s.den};
    r = s;
    r.rem = ge ? 15'(sh - {1'b0, s.den}) : sh[14:0];
    r.dvd = {s.dvd[QW-2:0], 1'b0};
    r.quo = {s.quo[QW-2:0], ge};
    return r;
  endfunction

  div_t          st  [QW+1];
  div_t          nxt [QW+1];
  logic [QW:0]   vld;
  logic [UW-1:0] u_next;

  assign nxt[0] = '{
    den: temp[14:0],
    rem: 15'(2 * dlxy_pkg::RECIP_NUM),
    dvd: QW'(temp[15:1]),
    quo: '0,
    tag: '{rng: (temp >= dlxy_pkg::TEMP_LOW) && (temp <= dlxy_pkg::TEMP_HIGH),
           sel: temp > dlxy_pkg::TEMP_SPLIT}
  };

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    assign nxt[k] = div_step(st[k-1]);
  end

  if (RECIP_FRAC_BITS > dlxy_pkg::WORK_BITS) begin : g_round
    localparam int URS = RECIP_FRAC_BITS - dlxy_pkg::WORK_BITS;
    logic [QW:0] usum;
    assign usum   = {1'b0, st[QW].quo} + ((QW+1)'(1) << (URS - 1));
    assign u_next = UW'(usum >> URS);
  end else begin : g_shift
    assign u_next = UW'(st[QW].quo) << (dlxy_pkg::WORK_BITS - RECIP_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[QW-1:0], in_valid};
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st  <= nxt;
      u   <= u_next;
      tag <= st[QW].tag;
    end
  end

endmodule

>>> rtl/dlxy_horner.sv
module dlxy_horner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [28:0]           u,
  input  dlxy_pkg::dlxy_tag_t   in_tag,
  output logic                  out_valid,
  output dlxy_pkg::dlxy_q30_t   x,
  output dlxy_pkg::dlxy_tag_t   out_tag
);

  localparam int UW = dlxy_pkg::U_WIDTH;
  localparam int HW = dlxy_pkg::Q_WIDTH;
  localparam int PW = HW + UW + 1;

  dlxy_pkg::dlxy_q30_t xs [4];
  logic [UW-1:0]       us [4];
  dlxy_pkg::dlxy_tag_t ts [4];
  logic                vs [4];

  assign xs[0] = in_tag.sel ? -dlxy_pkg::COEF_A2 : -dlxy_pkg::COEF_A1;
  assign us[0] = u;
  assign ts[0] = in_tag;
  assign vs[0] = in_valid;

  for (genvar k = 0; k < 3; k++) begin : g_step
    localparam dlxy_pkg::dlxy_q30_t CoefLo =
      (k == 0) ? dlxy_pkg::COEF_B1 : (k == 1) ? dlxy_pkg::COEF_C1 : dlxy_pkg::COEF_D1;
    localparam dlxy_pkg::dlxy_q30_t CoefHi =
      (k == 0) ? dlxy_pkg::COEF_B2 : (k == 1) ? dlxy_pkg::COEF_C2 : dlxy_pkg::COEF_D2;

    logic signed [PW-1:0] prod;
    logic [UW-1:0]        mu;
    logic [UW-1:0]        au;
    dlxy_pkg::dlxy_tag_t  mt;
    dlxy_pkg::dlxy_tag_t  at;
    dlxy_pkg::dlxy_q30_t  ax;
    logic                 mv;
    logic                 av;

    always_ff @(posedge clk) begin
      if (rst) begin
        mv <= 1'b0;
        av <= 1'b0;
      end else if (en) begin
        mv <= vs[k];
        av <= mv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod <= xs[k] * $signed({1'b0, us[k]});
        mu   <= us[k];
        mt   <= ts[k];
        ax   <= HW'(dlxy_pkg::qround(68'(prod))) + (mt.sel ? CoefHi : CoefLo);
        au   <= mu;
        at   <= mt;
      end
    end

    assign xs[k+1] = ax;
    assign us[k+1] = au;
    assign ts[k+1] = at;
    assign vs[k+1] = av;
  end

  assign x         = xs[3];
  assign out_tag   = ts[3];
  assign out_valid = vs[3];

endmodule

>>> rtl/dlxy_ylocus.sv
module dlxy_ylocus #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  dlxy_pkg::dlxy_q30_t   x,
  input  dlxy_pkg::dlxy_tag_t   in_tag,
  output logic                  out_valid,
  output dlxy_pkg::dlxy_res_t   res
);

  localparam int          HW  = dlxy_pkg::Q_WIDTH;
  localparam int          SH  = dlxy_pkg::WORK_BITS - OUT_FRAC_BITS;
  localparam logic [HW:0] RND = (HW+1)'(1) << (SH - 1);
  localparam logic [HW:0] LIM = (OUT_FRAC_BITS >= 16) ? (HW+1)'(16'hFFFF) :
                                ((HW+1)'(1) << OUT_FRAC_BITS) - (HW+1)'(1);

  function automatic logic [15:0] to_out(input dlxy_pkg::dlxy_q30_t v);
    logic [HW:0] r;
    r = ({1'b0, v} + RND) >> SH;
    if (v[HW-1] || v == '0) begin
      return 16'd0;
    end else if (r > LIM) begin
      return LIM[15:0];
    end else begin
      return r[15:0];
    end
  endfunction

  logic signed [31:0]   xa;
  logic signed [63:0]   sq;
  logic signed [31:0]   xsq;
  logic signed [65:0]   pa;
  logic signed [65:0]   pb;
  logic signed [31:0]   x1;
  logic signed [31:0]   x2;
  logic signed [31:0]   x3;
  dlxy_pkg::dlxy_q30_t  x4;
  dlxy_pkg::dlxy_q30_t  y4;
  dlxy_pkg::dlxy_tag_t  t1;
  dlxy_pkg::dlxy_tag_t  t2;
  dlxy_pkg::dlxy_tag_t  t3;
  dlxy_pkg::dlxy_tag_t  t4;
  logic [4:0]           vld;

  assign xa = $signed(x[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= xa * xa;
      x1  <= xa;
      t1  <= in_tag;
      xsq <= 32'(dlxy_pkg::qround(68'(sq)));
      x2  <= x1;
      t2  <= t1;
      pa  <= dlxy_pkg::COEF_YA * xsq;
      pb  <= dlxy_pkg::COEF_YB * x2;
      x3  <= x2;
      t3  <= t2;
      y4  <= HW'(dlxy_pkg::qround(68'(pb))) - HW'(dlxy_pkg::qround(68'(pa)))
             - dlxy_pkg::COEF_YC;
      x4  <= HW'(x3);
      t4  <= t3;
      res.rng <= t4.rng;
      res.cx  <= t4.rng ? to_out(x4) : 16'd0;
      res.cy  <= t4.rng ? to_out(y4) : 16'd0;
    end
  end

  assign out_valid = vld[4];

endmodule

>>> rtl/dlxy_outbuf.sv
module dlxy_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  dlxy_pkg::dlxy_res_t   in_res,
  output logic                  ready,
  output logic                  out_valid,
  output dlxy_pkg::dlxy_res_t   out_res,
  input  logic                  out_ready
);

  logic                skid_valid;
  dlxy_pkg::dlxy_res_t skid_res;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : in_res;
    end
    if (out_valid && !out_ready && !skid_valid) begin
      skid_res <= in_res;
    end
  end

endmodule

>>> rtl/daylight_locus_xy_from_cct.sv
// Daylight locus: takes a correlated color temperature in kelvin and returns the
// CIE daylight chromaticity x and y in unsigned Q0.OUT_FRAC_BITS, with in_range
// set for 4000..25000 K and x = y = 0 otherwise. One item is accepted every
// cycle while s_tready is high. The depth comes from the reciprocal 1000/T, a
// pipelined restoring divider that resolves one quotient bit per stage,
// followed by six stages of cubic Horner evaluation and five stages for y and
// output rounding. The output register has one skid entry: s_tready falls when
// a new result arrives while the output holds one with m_tready low, and the
// whole pipeline holds while it is low.
module daylight_locus_xy_from_cct #(
  parameter int OUT_FRAC_BITS   = 16,
  parameter int RECIP_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] temp_kelvin
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] chroma_x, [31:16] chroma_y
  output logic        m_tuser    // [0] in_range
);

  logic                en;
  logic                rc_valid;
  logic [28:0]         rc_u;
  dlxy_pkg::dlxy_tag_t rc_tag;
  logic                hn_valid;
  dlxy_pkg::dlxy_q30_t hn_x;
  dlxy_pkg::dlxy_tag_t hn_tag;
  logic                yl_valid;
  dlxy_pkg::dlxy_res_t yl_res;
  dlxy_pkg::dlxy_res_t ob_res;

  assign s_tready = en;

  dlxy_recip #(
    .RECIP_FRAC_BITS(RECIP_FRAC_BITS)
  ) u_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .temp     (s_tdata),
    .out_valid(rc_valid),
    .u        (rc_u),
    .tag      (rc_tag)
  );

  dlxy_horner u_horner (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rc_valid),
    .u        (rc_u),
    .in_tag   (rc_tag),
    .out_valid(hn_valid),
    .x        (hn_x),
    .out_tag  (hn_tag)
  );

  dlxy_ylocus #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_ylocus (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (hn_valid),
    .x        (hn_x),
    .in_tag   (hn_tag),
    .out_valid(yl_valid),
    .res      (yl_res)
  );

  dlxy_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (yl_valid),
    .in_res   (yl_res),
    .ready    (en),
    .out_valid(m_tvalid),
    .out_res  (ob_res),
    .out_ready(m_tready)
  );

  assign m_tdata = {ob_res.cy, ob_res.cx};
  assign m_tuser = ob_res.rng;

endmodule

>>> rtl/dlxy_checker.sv
module dlxy_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_zero_out_of_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("out-of-range item with nonzero chromaticity");

  a_nonzero_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] != 16'd0 && m_tdata[31:16] != 16'd0)
    else $error("in-range item with zero chromaticity");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind daylight_locus_xy_from_cct dlxy_checker u_checker (.*);

>>> test/daylight_locus_xy_from_cct_test.sv
module daylight_locus_xy_from_cct_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_TEMPS = 1030;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          HOLD_CYCLES  = 250;
  localparam logic [15:0] T_LOW        = 16'd4000;
  localparam logic [15:0] T_SPLIT      = 16'd7000;
  localparam logic [15:0] T_HIGH       = 16'd25000;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        in_rng;
  } chroma_t;

  class locus_scoreboard;
    chroma_t expected_q[$];
    int      mismatches;
    longint  ka1, kb1, kc1, kd1, ka2, kb2, kc2, kd2, kya, kyb, kyc;

    function new();
      mismatches = 0;
      ka1 = q30_of(46070, 10000);
      kb1 = q30_of(29678, 10000);
      kc1 = q30_of(9911, 100000);
      kd1 = q30_of(244063, 1000000);
      ka2 = q30_of(20064, 10000);
      kb2 = q30_of(19018, 10000);
      kc2 = q30_of(24748, 100000);
      kd2 = q30_of(237040, 1000000);
      kya = q30_of(3, 1);
      kyb = q30_of(2870, 1000);
      kyc = q30_of(275, 1000);
    endfunction

    function longint q30_of(longint unsigned n, longint unsigned d);
      return longint'(((n << 31) + d) / (2 * d));
    endfunction

    function longint mul_q30(longint a, longint b);
      bit                neg;
      longint unsigned   ma, mb, m;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      m   = (ma * mb + (64'd1 << 29)) >> 30;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function logic [15:0] to_q16(longint v);
      longint unsigned r;
      if (v <= 0) return 16'd0;
      r = ($unsigned(v) + (64'd1 << 13)) >> 14;
      return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function chroma_t locus_point(logic [15:0] t);
      chroma_t         p;
      longint unsigned recip;
      longint          u, x, y, a, b, c, d;
      p.x = 16'd0;
      p.y = 16'd0;
      p.in_rng = 1'b0;
      if (t < T_LOW || t > T_HIGH) return p;
      recip = ((64'd1000 << 24) + (t / 2)) / t;
      u = longint'(recip << 6);
      if (t <= T_SPLIT) begin
        a = ka1; b = kb1; c = kc1; d = kd1;
      end else begin
        a = ka2; b = kb2; c = kc2; d = kd2;
      end
      x = -a;
      x = mul_q30(x, u) + b;
      x = mul_q30(x, u) + c;
      x = mul_q30(x, u) + d;
      y = -mul_q30(kya, mul_q30(x, x)) + mul_q30(kyb, x) - kyc;
      p.x = to_q16(x);
      p.y = to_q16(y);
      p.in_rng = 1'b1;
      return p;
    endfunction

    function void note_temp(logic [15:0] t);
      expected_q.push_back(locus_point(t));
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_result(logic [15:0] x, logic [15:0] y, logic in_rng);
      chroma_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result, chroma_x", 0, x);
        return;
      end
      e = expected_q.pop_front();
      if (x !== e.x) report("chroma_x", e.x, x);
      if (y !== e.y) report("chroma_y", e.y, y);
      if (in_rng !== e.in_rng) report("in_range", e.in_rng, in_rng);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  locus_scoreboard chroma_sb = new();
  int              temps_sent = 0;
  int              cycle_count = 0;
  logic            rx_hold = 1'b0;
  bit              tx_idle_on = 1'b1;

  daylight_locus_xy_from_cct DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_temp(input logic [15:0] t);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    chroma_sb.note_temp(t);
    temps_sent++;
  endtask

  function automatic logic [15:0] pick_temp();
    int unsigned k;
    logic [15:0] edges[3];
    k = $urandom_range(0, 19);
    edges[0] = T_LOW;
    edges[1] = T_SPLIT;
    edges[2] = T_HIGH;
    if (k < 8) return 16'($urandom_range(T_LOW, T_SPLIT));
    if (k < 14) return 16'($urandom_range(T_SPLIT + 1, T_HIGH));
    if (k < 16) return edges[$urandom_range(0, 2)] + 16'($urandom_range(0, 4)) - 16'd2;
    if (k < 18) return 16'($urandom_range(0, 65535));
    if (k < 19) return 16'($urandom_range(0, T_LOW - 1));
    return 16'($urandom_range(T_HIGH + 1, 65535));
  endfunction

  initial begin
    logic [15:0] directed[] = '{16'd0, 16'd1, 16'd3999, 16'd4000, 16'd4001, 16'd5000,
                                16'd6500, 16'd6999, 16'd7000, 16'd7001, 16'd7002,
                                16'd10000, 16'd15000, 16'd20000, 16'd24999, 16'd25000,
                                16'd25001, 16'd32768, 16'h5555, 16'hAAAA, 16'hFFFF};
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_temp(directed[i]);
    for (int n = 0; n < RANDOM_TEMPS; n++) begin
      if (n % 100 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      send_temp(pick_temp());
    end
    s_tvalid <= 1'b0;
    waited = 0;
    while (chroma_sb.pending() != 0) begin
      @(posedge clk);
      waited++;
      if (waited > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chroma_sb.pending() != 0 || chroma_sb.mismatches != 0) begin
      $display("CHECKS FAILED");
    end else begin
      $display("ALL CHECKS PASSED");
    end
    $finish;
  end

  initial begin
    int  stall;
    int  taken;
    bit  rx_idle_on;
    taken = 0;
    rx_idle_on = 1'b1;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 100 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      stall = rx_idle_on ? $urandom_range(0, 4) : 0;
      while (rx_hold || stall > 0) begin
        m_tready <= 1'b0;
        @(posedge clk);
        if (stall > 0) stall--;
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      chroma_sb.check_result(m_tdata[15:0], m_tdata[31:16], m_tuser);
      taken++;
    end
  end

  initial begin
    int hold_points[] = '{300, 750};
    foreach (hold_points[i]) begin
      wait (temps_sent >= hold_points[i]);
      @(posedge clk);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

endmodule
